FILE: hw/rtl/pngw_pkg.sv
`default_nettype none

package pngw_pkg;

  // Field and counter widths.
  localparam int unsigned DimW    = 14;
  localparam int unsigned ColW    = 13;
  localparam int unsigned RawW    = 29;
  localparam int unsigned RawMulW = 2 * DimW + 2;
  localparam int unsigned LenW    = 32;
  localparam int unsigned BlkLenW = 16;
  localparam int unsigned CfgIdxW = 2;

  // Image size limit and stored block size.
  localparam logic [DimW-1:0] MaxDim = DimW'(8192);
  localparam int unsigned StoredBlockBytes = 65535;

  // Block count by reciprocal multiplication: ceil(raw / StoredBlockBytes).
  localparam int unsigned YW          = RawW + 1;
  localparam int unsigned RecipShift  = 30;
  localparam int unsigned RecipW      = 27;
  localparam int unsigned ProdW       = YW + RecipW;
  localparam int unsigned BlkCntW     = 26;
  localparam logic [RecipW-1:0] Recip = RecipW'((64'd1 << RecipShift) / StoredBlockBytes);

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegImageWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegImageHeight = CfgIdxW'(1);

  // Chunk type words and other fixed file contents.
  localparam logic [31:0] TypeIhdr = 32'h49484452;
  localparam logic [31:0] TypeIdat = 32'h49444154;
  localparam logic [31:0] TypeIend = 32'h49454E44;
  localparam logic [31:0] IhdrLen  = 32'd13;
  localparam logic [31:0] CrcPoly  = 32'hEDB88320;
  localparam logic [15:0] AdlerMod = 16'd65521;
  localparam logic [7:0]  ZlibCmf  = 8'h78;
  localparam logic [7:0]  ZlibFlg  = 8'h01;
  localparam logic [63:0] PngMagic = 64'h89504E470D0A1A0A;

  // Sequence positions in the header and the trailer.
  localparam logic [5:0] HdrLast = 6'd42;
  localparam logic [4:0] TrlLast = 5'd19;

  typedef enum logic [1:0] {
    BkIdle,
    BkHeader,
    BkRaw,
    BkTrailer
  } back_state_e;

  // One pixel as classified by the front end.
  typedef struct packed {
    logic       first_px;
    logic       row_start;
    logic       last_px;
    logic       split;
    logic       flush;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } item_t;

  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
  } dims_t;

  // Byte-wise CRC-32 update, reflected polynomial.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'h0);
    end
    return c;
  endfunction

  // Big-endian byte of a 32-bit word.
  function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] sel);
    logic [7:0] r;
    case (sel)
      2'd0:    r = w[31:24];
      2'd1:    r = w[23:16];
      2'd2:    r = w[15:8];
      default: r = w[7:0];
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pngw_queue.sv
`default_nettype none

module pngw_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  pngw_pkg::item_t  item_i,
  output logic             full_o,
  input  wire              pop_i,
  output pngw_pkg::item_t  head_o,
  output logic             head_valid_o
);
  import pngw_pkg::*;

  item_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = slot_q[rd_ptr_q];

endmodule

`default_nettype wire

FILE: hw/rtl/pngw_front.sv
`default_nettype none

module pngw_front (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [pngw_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire [pngw_pkg::DimW-1:0]         cfg_wdata_i,
  input  wire                              accept_i,
  input  wire [7:0]                        red_i,
  input  wire [7:0]                        green_i,
  input  wire [7:0]                        blue_i,
  input  wire [7:0]                        alpha_i,
  output pngw_pkg::item_t                  item_o,
  output pngw_pkg::dims_t                  dims_o
);
  import pngw_pkg::*;

  logic [DimW-1:0] width_q, height_q;
  dims_t           cur_q;
  logic [ColW-1:0] col_q, row_q;
  logic            open_q, hold_q;
  logic [DimW-1:0] cfg_val;
  dims_t           dims;
  logic [ColW-1:0] col, row;
  logic            last_px;

  // Saturate dimension writes into the legal range.
  always_comb begin
    cfg_val = cfg_wdata_i;
    if (cfg_val > MaxDim) begin
      cfg_val = MaxDim;
    end
    if (cfg_val == '0) begin
      cfg_val = DimW'(1);
    end
  end

  // Classify the incoming pixel against the open image.
  always_comb begin
    dims.width  = open_q ? cur_q.width : width_q;
    dims.height = open_q ? cur_q.height : height_q;
    col         = open_q ? col_q : '0;
    row         = open_q ? row_q : '0;
    last_px     = ({1'b0, col} == dims.width - DimW'(1)) &&
                  ({1'b0, row} == dims.height - DimW'(1));
    item_o.first_px  = !hold_q && !open_q;
    item_o.row_start = (col == '0);
    item_o.last_px   = !hold_q && last_px;
    item_o.split     = !hold_q && !open_q && last_px;
    item_o.flush     = hold_q;
    item_o.red       = red_i;
    item_o.green     = green_i;
    item_o.blue      = blue_i;
    item_o.alpha     = alpha_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= DimW'(1);
      height_q     <= DimW'(1);
      cur_q.width  <= DimW'(1);
      cur_q.height <= DimW'(1);
      col_q        <= '0;
      row_q        <= '0;
      open_q       <= 1'b0;
      hold_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegImageWidth) begin
          width_q <= cfg_val;
        end else if (cfg_idx_i == RegImageHeight) begin
          height_q <= cfg_val;
        end
      end
      if (accept_i) begin
        if (hold_q) begin
          hold_q <= 1'b0;
        end else begin
          if (!open_q) begin
            cur_q <= dims;
          end
          if (last_px) begin
            open_q <= 1'b0;
            col_q  <= '0;
            row_q  <= '0;
            hold_q <= !open_q;
          end else begin
            open_q <= 1'b1;
            if ({1'b0, col} == dims.width - DimW'(1)) begin
              col_q <= '0;
              row_q <= row + ColW'(1);
            end else begin
              col_q <= col + ColW'(1);
              row_q <= row;
            end
          end
        end
      end
    end
  end

  assign dims_o = cur_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pngw_back.sv
`default_nettype none

module pngw_back (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  pngw_pkg::dims_t  dims_i,
  input  pngw_pkg::item_t  head_i,
  input  wire              head_valid_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             last_of_run_o,
  output logic             end_of_image_o
);
  import pngw_pkg::*;

  back_state_e        state_q, state_d, eff_state;
  logic [5:0]         hdr_idx_q, hdr_idx_d;
  logic [2:0]         blk_idx_q, blk_idx_d;
  logic [2:0]         raw_idx_q, raw_idx_d, eff_raw_idx;
  logic [4:0]         trl_idx_q, trl_idx_d;
  logic [31:0]        crc_q, crc_d;
  logic [15:0]        adl_lo_q, adl_lo_d, adl_hi_q, adl_hi_d;
  logic [RawW-1:0]    raw_left_q, raw_left_d;
  logic [BlkLenW-1:0] blk_left_q, blk_left_d;

  logic [RawW-1:0]    raw_q;
  logic [ProdW-1:0]   prod_q;
  logic [BlkCntW-1:0] q0_q, blocks_q;
  logic [YW-1:0]      rem_q;
  logic [LenW-1:0]    len_q;
  logic [YW-1:0]      y;
  logic [RawMulW-1:0] raw_mul;

  logic               out_valid_q;
  logic [7:0]         out_byte_q;
  logic               run_end_q, img_end_q;

  logic               advance, go, feed, crc_rst, adl_feed, run_end, img_end;
  logic [7:0]         byte_v;
  logic [BlkLenW-1:0] n;
  logic [BlkLenW-1:0] nn;
  logic [16:0]        lo_sum;
  logic [16:0]        hi_sum;
  logic [15:0]        lo_new;
  logic [1:0]         sel;

  // Stream length chain: raw size, then block count, then IDAT length.
  // The latched dimensions stay put for far longer than this chain needs.
  assign raw_mul = RawMulW'(dims_i.height) * RawMulW'({dims_i.width, 2'b01});
  assign y       = YW'(raw_q) + YW'(StoredBlockBytes - 1);

  always_ff @(posedge clk_i) begin
    raw_q    <= raw_mul[RawW-1:0];
    prod_q   <= ProdW'(y) * ProdW'(Recip);
    q0_q     <= prod_q[RecipShift +: BlkCntW];
    rem_q    <= y - YW'(YW'(q0_q) * YW'(StoredBlockBytes));
    blocks_q <= q0_q + BlkCntW'(rem_q >= YW'(StoredBlockBytes));
    len_q    <= LenW'(raw_q) + LenW'(6) + LenW'({blocks_q, 2'b00}) + LenW'(blocks_q);
  end

  // Size of the next stored block and its complement.
  always_comb begin
    if (raw_left_q < RawW'(StoredBlockBytes)) begin
      n = raw_left_q[BlkLenW-1:0];
    end else begin
      n = BlkLenW'(StoredBlockBytes);
    end
    nn = ~n;
  end

  assign advance = !out_valid_q || out_ready_i;
  assign go      = head_valid_i && advance;

  // Byte sequencer: picks the next byte of the file and advances.
  always_comb begin
    state_d    = state_q;
    hdr_idx_d  = hdr_idx_q;
    blk_idx_d  = blk_idx_q;
    raw_idx_d  = raw_idx_q;
    trl_idx_d  = trl_idx_q;
    raw_left_d = raw_left_q;
    blk_left_d = blk_left_q;
    crc_d      = crc_q;
    adl_lo_d   = adl_lo_q;
    adl_hi_d   = adl_hi_q;
    pop_o      = 1'b0;
    byte_v     = 8'h00;
    feed       = 1'b0;
    crc_rst    = 1'b0;
    adl_feed   = 1'b0;
    run_end    = 1'b0;
    img_end    = 1'b0;
    sel        = 2'd0;

    // A new transaction starts straight in its first phase.
    if (state_q == BkIdle) begin
      if (head_i.flush) begin
        eff_state = BkTrailer;
      end else if (head_i.first_px) begin
        eff_state = BkHeader;
      end else begin
        eff_state = BkRaw;
      end
      eff_raw_idx = head_i.row_start ? 3'd0 : 3'd1;
    end else begin
      eff_state   = state_q;
      eff_raw_idx = raw_idx_q;
    end

    unique case (eff_state)
      BkHeader: begin
        case (hdr_idx_q) inside
          [6'd0:6'd7]: begin
            byte_v = PngMagic[8 * (7 - 32'(hdr_idx_q[2:0])) +: 8];
          end
          [6'd8:6'd11]: begin
            byte_v = be_byte(IhdrLen, hdr_idx_q[1:0]);
          end
          [6'd12:6'd15]: begin
            byte_v = be_byte(TypeIhdr, hdr_idx_q[1:0]);
            feed   = 1'b1;
          end
          [6'd16:6'd19]: begin
            byte_v = be_byte(32'(dims_i.width), hdr_idx_q[1:0]);
            feed   = 1'b1;
          end
          [6'd20:6'd23]: begin
            byte_v = be_byte(32'(dims_i.height), hdr_idx_q[1:0]);
            feed   = 1'b1;
          end
          6'd24: begin
            byte_v = 8'd8;
            feed   = 1'b1;
          end
          6'd25: begin
            byte_v = 8'd6;
            feed   = 1'b1;
          end
          [6'd26:6'd28]: begin
            byte_v = 8'd0;
            feed   = 1'b1;
          end
          [6'd29:6'd32]: begin
            sel    = 2'(hdr_idx_q - 6'd29);
            byte_v = be_byte(~crc_q, sel);
          end
          [6'd33:6'd36]: begin
            sel    = 2'(hdr_idx_q - 6'd33);
            byte_v = be_byte(len_q, sel);
          end
          [6'd37:6'd40]: begin
            sel    = 2'(hdr_idx_q - 6'd37);
            byte_v = be_byte(TypeIdat, sel);
            feed   = 1'b1;
          end
          6'd41: begin
            byte_v = ZlibCmf;
            feed   = 1'b1;
          end
          default: begin
            byte_v = ZlibFlg;
            feed   = 1'b1;
          end
        endcase
        crc_rst = (hdr_idx_q == 6'd12) || (hdr_idx_q == 6'd37);
        if (go) begin
          if (hdr_idx_q == HdrLast) begin
            state_d    = BkRaw;
            hdr_idx_d  = '0;
            raw_idx_d  = 3'd0;
            raw_left_d = raw_q;
            blk_left_d = '0;
            adl_lo_d   = 16'd1;
            adl_hi_d   = 16'd0;
          end else begin
            state_d   = BkHeader;
            hdr_idx_d = hdr_idx_q + 6'd1;
          end
        end
      end

      BkRaw: begin
        feed = 1'b1;
        if (blk_left_q == '0) begin
          // Stored block header ahead of the next raw byte.
          case (blk_idx_q)
            3'd0:    byte_v = {7'd0, ({{(RawW-BlkLenW){1'b0}}, n} == raw_left_q)};
            3'd1:    byte_v = n[7:0];
            3'd2:    byte_v = n[15:8];
            3'd3:    byte_v = nn[7:0];
            default: byte_v = nn[15:8];
          endcase
          if (go) begin
            state_d   = BkRaw;
            raw_idx_d = eff_raw_idx;
            if (blk_idx_q == 3'd4) begin
              blk_idx_d  = '0;
              blk_left_d = n;
            end else begin
              blk_idx_d = blk_idx_q + 3'd1;
            end
          end
        end else begin
          case (eff_raw_idx)
            3'd0:    byte_v = 8'h00;
            3'd1:    byte_v = head_i.red;
            3'd2:    byte_v = head_i.green;
            3'd3:    byte_v = head_i.blue;
            default: byte_v = head_i.alpha;
          endcase
          adl_feed = 1'b1;
          if (eff_raw_idx == 3'd4) begin
            run_end = !(head_i.last_px && !head_i.split);
          end
          if (go) begin
            blk_left_d = blk_left_q - BlkLenW'(1);
            raw_left_d = raw_left_q - RawW'(1);
            if (eff_raw_idx == 3'd4) begin
              if (head_i.last_px && !head_i.split) begin
                state_d = BkTrailer;
              end else begin
                state_d = BkIdle;
                pop_o   = 1'b1;
              end
            end else begin
              state_d   = BkRaw;
              raw_idx_d = eff_raw_idx + 3'd1;
            end
          end
        end
      end

      BkTrailer: begin
        case (trl_idx_q[4:2])
          3'd0: begin
            byte_v = be_byte({adl_hi_q, adl_lo_q}, trl_idx_q[1:0]);
            feed   = 1'b1;
          end
          3'd1:    byte_v = be_byte(~crc_q, trl_idx_q[1:0]);
          3'd2:    byte_v = 8'h00;
          3'd3: begin
            byte_v = be_byte(TypeIend, trl_idx_q[1:0]);
            feed   = 1'b1;
          end
          default: byte_v = be_byte(~crc_q, trl_idx_q[1:0]);
        endcase
        crc_rst = (trl_idx_q == 5'd12);
        if (trl_idx_q == TrlLast) begin
          run_end = 1'b1;
          img_end = 1'b1;
        end
        if (go) begin
          if (trl_idx_q == TrlLast) begin
            state_d   = BkIdle;
            trl_idx_d = '0;
            pop_o     = 1'b1;
          end else begin
            state_d   = BkTrailer;
            trl_idx_d = trl_idx_q + 5'd1;
          end
        end
      end

      default: begin
      end
    endcase

    // Running checksums over the bytes that go out.
    if (go && feed) begin
      crc_d = crc32_byte(crc_rst ? 32'hFFFFFFFF : crc_q, byte_v);
    end
    lo_sum = {1'b0, adl_lo_q} + 17'(byte_v);
    lo_new = (lo_sum >= 17'(AdlerMod)) ? 16'(lo_sum - 17'(AdlerMod)) : lo_sum[15:0];
    hi_sum = {1'b0, adl_hi_q} + {1'b0, lo_new};
    if (go && adl_feed) begin
      adl_lo_d = lo_new;
      adl_hi_d = (hi_sum >= 17'(AdlerMod)) ? 16'(hi_sum - 17'(AdlerMod)) : hi_sum[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      hdr_idx_q   <= '0;
      blk_idx_q   <= '0;
      raw_idx_q   <= '0;
      trl_idx_q   <= '0;
      raw_left_q  <= '0;
      blk_left_q  <= '0;
      crc_q       <= 32'hFFFFFFFF;
      adl_lo_q    <= 16'd1;
      adl_hi_q    <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      hdr_idx_q  <= hdr_idx_d;
      blk_idx_q  <= blk_idx_d;
      raw_idx_q  <= raw_idx_d;
      trl_idx_q  <= trl_idx_d;
      raw_left_q <= raw_left_d;
      blk_left_q <= blk_left_d;
      crc_q      <= crc_d;
      adl_lo_q   <= adl_lo_d;
      adl_hi_q   <= adl_hi_d;
      if (advance) begin
        out_valid_q <= go;
      end
    end
  end

  // Output register holding the byte on offer.
  always_ff @(posedge clk_i) begin
    if (go) begin
      out_byte_q <= byte_v;
      run_end_q  <= run_end;
      img_end_q  <= img_end;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign last_of_run_o  = run_end_q;
  assign end_of_image_o = img_end_q;

endmodule

`default_nettype wire

FILE: hw/rtl/png_stored_stream_writer_top.sv
`default_nettype none

// Streams RGBA pixels in raster order and produces the bytes of a complete
// uncompressed PNG file, one byte per cycle on the output channel unless it is
// stalled. The first pixel of an image brings out 43 header bytes ahead of
// its data, every row starts with a zero filter byte, every 65535 raw bytes
// start a 5-byte stored block header, and the last pixel brings out a 20-byte
// trailer. A typical pixel therefore yields 4 bytes, 5 at the start of a row,
// plus 5 more when a new block begins.
// A front end classifies each accepted pixel and hands it through a
// two-entry queue to the byte sequencer, so input can be taken while output
// is stalled. Width and height are latched at the first pixel of each image.
// For a one-pixel image the file is split: the first pixel yields 53 bytes
// and the next pixel, whose value is ignored, yields the 20-byte trailer.
module png_stored_stream_writer_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [pngw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [pngw_pkg::DimW-1:0]     cfg_wdata_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire [7:0]                    red_i,
  input  wire [7:0]                    green_i,
  input  wire [7:0]                    blue_i,
  input  wire [7:0]                    alpha_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [7:0]                   out_byte_o,
  output logic                         last_of_run_o,
  output logic                         end_of_image_o
);
  import pngw_pkg::*;

  item_t item, head;
  dims_t dims;
  logic  full, head_valid, pop, accept;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && !full;

  // Pixel classification and image bookkeeping.
  pngw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .alpha_i     (alpha_i),
    .item_o      (item),
    .dims_o      (dims)
  );

  // Decoupling queue between classification and byte generation.
  pngw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept),
    .item_i       (item),
    .full_o       (full),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid)
  );

  // Byte sequencer with checksums and the output register.
  pngw_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .dims_i         (dims),
    .head_i         (head),
    .head_valid_i   (head_valid),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_image_o (end_of_image_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/png_stored_stream_writer_top_tb.sv
`default_nettype none

module png_stored_stream_writer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pngw_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RunMax      = 53;
  localparam int unsigned BlockBytes  = 65535;
  localparam int unsigned DimLimit    = 8192;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       file_end;
  } file_byte_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = RegImageWidth;
  logic [DimW-1:0]     cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [7:0]          red_i = '0;
  logic [7:0]          green_i = '0;
  logic [7:0]          blue_i = '0;
  logic [7:0]          alpha_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [7:0]          out_byte_o;
  logic                last_of_run_o;
  logic                end_of_image_o;

  png_stored_stream_writer_top dut (.*);

  always #2 clk_i = ~clk_i;

  // Pixels waiting to be sent and file bytes waiting to come out.
  pixel_t     pixel_q[$];
  file_byte_t file_byte_q[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Encoder shadow state.
  int unsigned reg_width = 1, reg_height = 1, img_width = 1, img_height = 1;
  int unsigned col_cnt = 0, blk_left = 0, raw_left = 0;
  logic [31:0] crc_acc = '1;
  int unsigned adl_lo = 1, adl_hi = 0;
  logic [7:0]  run_bytes[$];
  logic [7:0]  trailer_hold[$];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void crc_update(input logic [7:0] b);
    logic [31:0] c;
    c = crc_acc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    crc_acc = c;
  endfunction

  function automatic void emit(input logic [7:0] b, input bit feed);
    run_bytes.insert(run_bytes.size(), b);
    if (feed) crc_update(b);
  endfunction

  function automatic void emit_word(input logic [31:0] w, input bit feed);
    for (int k = 3; k >= 0; k--) emit(w[8*k +: 8], feed);
  endfunction

  function automatic void emit_chunk_type(input string s);
    for (int k = 0; k < 4; k++) emit(s[k], 1'b1);
  endfunction

  // Raw zlib payload byte, opening a stored block when the last one is full.
  function automatic void emit_raw(input logic [7:0] b);
    int unsigned n;
    logic [15:0] len, nlen;
    if (blk_left == 0) begin
      n = (raw_left < BlockBytes) ? raw_left : BlockBytes;
      len = n[15:0];
      nlen = ~len;
      emit((n == raw_left) ? 8'd1 : 8'd0, 1'b1);
      emit(len[7:0], 1'b1);
      emit(len[15:8], 1'b1);
      emit(nlen[7:0], 1'b1);
      emit(nlen[15:8], 1'b1);
      blk_left = n;
    end
    emit(b, 1'b1);
    adl_lo = (adl_lo + b) % 65521;
    adl_hi = (adl_hi + adl_lo) % 65521;
    blk_left--;
    raw_left--;
  endfunction

  function automatic void open_image();
    int unsigned raw, blocks;
    logic [63:0] magic;
    magic = 64'h89504E470D0A1A0A;
    img_width = reg_width;
    img_height = reg_height;
    raw = img_height * (img_width * 4 + 1);
    blocks = (raw + BlockBytes - 1) / BlockBytes;
    for (int k = 7; k >= 0; k--) emit(magic[8*k +: 8], 1'b0);
    emit_word(32'd13, 1'b0);
    crc_acc = '1;
    emit_chunk_type("IHDR");
    emit_word(img_width, 1'b1);
    emit_word(img_height, 1'b1);
    emit(8'd8, 1'b1);
    emit(8'd6, 1'b1);
    emit(8'd0, 1'b1);
    emit(8'd0, 1'b1);
    emit(8'd0, 1'b1);
    emit_word(~crc_acc, 1'b0);
    emit_word(2 + 5 * blocks + raw + 4, 1'b0);
    crc_acc = '1;
    emit_chunk_type("IDAT");
    emit(8'h78, 1'b1);
    emit(8'h01, 1'b1);
    raw_left = raw;
    blk_left = 0;
    col_cnt = 0;
    adl_lo = 1;
    adl_hi = 0;
  endfunction

  function automatic void close_image();
    emit(adl_hi[15:8], 1'b1);
    emit(adl_hi[7:0], 1'b1);
    emit(adl_lo[15:8], 1'b1);
    emit(adl_lo[7:0], 1'b1);
    emit_word(~crc_acc, 1'b0);
    emit_word(32'd0, 1'b0);
    crc_acc = '1;
    emit_chunk_type("IEND");
    emit_word(~crc_acc, 1'b0);
    col_cnt = 0;
    blk_left = 0;
    raw_left = 0;
    crc_acc = '1;
    adl_lo = 1;
    adl_hi = 0;
  endfunction

  // Expected file bytes for one accepted pixel.
  function automatic void encode_pixel(input pixel_t px);
    bit done;
    int unsigned n;
    file_byte_t fb;
    if (trailer_hold.size() != 0) begin
      foreach (trailer_hold[k]) begin
        fb.data = trailer_hold[k];
        fb.run_end = (k == trailer_hold.size() - 1);
        fb.file_end = fb.run_end;
        file_byte_q.insert(file_byte_q.size(), fb);
      end
      trailer_hold.delete();
      return;
    end
    run_bytes.delete();
    if (raw_left == 0) open_image();
    if (col_cnt == 0) emit_raw(8'd0);
    emit_raw(px.red);
    emit_raw(px.green);
    emit_raw(px.blue);
    emit_raw(px.alpha);
    col_cnt++;
    if (col_cnt >= img_width) col_cnt = 0;
    done = (raw_left == 0);
    if (done) close_image();
    n = run_bytes.size();
    if (n > RunMax) begin
      for (int k = RunMax; k < n; k++) trailer_hold.insert(trailer_hold.size(), run_bytes[k]);
      n = RunMax;
      done = 1'b0;
    end
    for (int k = 0; k < n; k++) begin
      fb.data = run_bytes[k];
      fb.run_end = (k == n - 1);
      fb.file_end = done && fb.run_end;
      file_byte_q.insert(file_byte_q.size(), fb);
    end
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 0, gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t px;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) encode_pixel({red_i, green_i, blue_i, alpha_i});
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          px = pixel_q.pop_front();
          in_valid_i <= 1'b1;
          {red_i, green_i, blue_i, alpha_i} <= px;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready follows a stall mode that is redrawn at random.
  logic [1:0] stall_mode = 2'd0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (cycle_count % 64 == 0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
        2'd0: out_ready_i <= 1'b1;
        2'd1: out_ready_i <= ($urandom_range(0, 1) == 0);
        2'd2: out_ready_i <= (cycle_count % 3 != 0);
        default: out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Output checker.
  always @(posedge clk_i) begin
    file_byte_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (file_byte_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", out_byte_o));
      end else begin
        want = file_byte_q.pop_front();
        if (out_byte_o !== want.data)
          report_mismatch($sformatf("byte %02h, want %02h", out_byte_o, want.data));
        if (last_of_run_o !== want.run_end)
          report_mismatch($sformatf("last_of_run %b, want %b", last_of_run_o, want.run_end));
        if (end_of_image_o !== want.file_end)
          report_mismatch($sformatf("end_of_image %b, want %b", end_of_image_o,
                                    want.file_end));
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("** png_stored_stream_writer_top: FAILED **");
      $finish;
    end
  end

  task automatic write_dim(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    int unsigned v;
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= DimW'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    v = val & 16'h3FFF;
    if (v > DimLimit) v = DimLimit;
    if (v == 0) v = 1;
    if (idx == RegImageWidth) reg_width = v;
    else reg_height = v;
  endtask

  task automatic queue_pixel(input pixel_t px);
    pixel_q.insert(pixel_q.size(), px);
  endtask

  task automatic queue_random(input int unsigned n);
    repeat (n) queue_pixel(pixel_t'($urandom()));
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || in_valid_i || file_byte_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    int unsigned w, h, sent;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // One-pixel image at reset dimensions; the second pixel brings the trailer.
    queue_pixel(32'h00000000);
    queue_pixel(32'hFFFFFFFF);
    drain();
    // Field extremes in a 2x2 image.
    write_dim(RegImageWidth, 2);
    write_dim(RegImageHeight, 2);
    queue_pixel(32'hFF00FF00);
    queue_pixel(32'h00FF00FF);
    queue_pixel(32'hFFFFFFFF);
    queue_pixel(32'h00000000);
    drain();

    // A width change mid-image must wait for the next image.
    queue_pixel(32'h12345678);
    drain();
    write_dim(RegImageWidth, 3);
    queue_random(3);
    drain();
    queue_random(6);
    drain();

    // Zero is taken as one.
    write_dim(RegImageWidth, 0);
    write_dim(RegImageHeight, 0);
    queue_random(2);
    drain();

    // Random small images.
    sent = 0;
    while (sent < 80) begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 4);
      write_dim(RegImageWidth, w);
      write_dim(RegImageHeight, h);
      queue_random(w * h + ((w * h == 1) ? 1 : 0));
      sent += w * h;
      drain();
    end

    // Oversized dimensions saturate; the header and the first pixels are checked.
    write_dim(RegImageWidth, 16383);
    write_dim(RegImageHeight, 9000);
    queue_random(3);
    drain();

    if (error_count == 0) begin
      $display("** png_stored_stream_writer_top: PASSED **");
    end else begin
      $display("** png_stored_stream_writer_top: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
